FILE: rtl/uxv_pkg.sv
// Shared types, constants and helper functions for the UTF-8 / XML scalar validator.
// Used by uxv_step, the top level and the port checker; depends on nothing else.
`timescale 1ns / 1ps

package uxv_pkg;

    // Width of the byte offset counters.
    localparam int OFFSET_BITS = 48;
    // Width of the reported position field.
    localparam int POS_BITS    = 48;
    localparam int CP_BITS     = 21;
    localparam int MIN_BITS    = 17;

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

    // Result status codes.
    localparam logic [2:0] ST_SCALAR    = 3'd0;
    localparam logic [2:0] ST_MALFORMED = 3'd1;
    localparam logic [2:0] ST_LIMIT     = 3'd2;
    localparam logic [2:0] ST_AFTER_END = 3'd3;
    localparam logic [2:0] ST_END_OK    = 3'd4;

    // Input mode codes.
    localparam logic MODE_DATA = 1'b0;
    localparam logic MODE_END  = 1'b1;

    // Smallest legal value for each multi-byte sequence length.
    localparam logic [MIN_BITS-1:0] MIN_TWO   = 17'h00080;
    localparam logic [MIN_BITS-1:0] MIN_THREE = 17'h00800;
    localparam logic [MIN_BITS-1:0] MIN_FOUR  = 17'h10000;

    // Decoder state carried from one byte to the next.
    typedef struct packed {
        logic [CP_BITS-1:0]     partial_value;
        logic [MIN_BITS-1:0]    minimum_value;
        logic [1:0]             bytes_remaining;
        logic [OFFSET_BITS-1:0] sequence_start;
        logic [OFFSET_BITS-1:0] byte_count;
        logic                   ended;
        logic                   failed;
        logic [2:0]             error_code;
        logic [OFFSET_BITS-1:0] error_position;
    } state_t;

    // One result item.
    typedef struct packed {
        logic [2:0]          status;
        logic [CP_BITS-1:0]  code_point;
        logic [POS_BITS-1:0] position;
    } result_t;

    // True for a value that XML allows as a character.
    function automatic logic xml_scalar_ok(input logic [CP_BITS-1:0] v);
        return v inside {21'h09, 21'h0A, 21'h0D, [21'h20:21'hD7FF],
                         [21'hE000:21'hFFFD], [21'h10000:21'h10FFFF]};
    endfunction

    // Fit an offset into the position field, truncating or zero-extending.
    function automatic logic [POS_BITS-1:0] off_to_pos(input logic [OFFSET_BITS-1:0] off);
        logic [63:0] wide;
        wide = 64'(off);
        return wide[POS_BITS-1:0];
    endfunction

endpackage

FILE: rtl/utf8_xml_scalar_validator.sv
// A result is registered and valid in the cycle after the request that causes it is accepted.
// Throughput: one byte or end request per cycle; the single output register sets the rate,
// and input stall rises only while that register holds a result the sink has stalled.
// Reset (rst_n low, asynchronous) clears the decoder state, the sticky error and the
// output valid; the block accepts requests in the first cycle after reset is released.
// Depends on uxv_pkg and uxv_step.
`timescale 1ns / 1ps

module utf8_xml_scalar_validator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         mode,
    input  logic [7:0]                   data_byte,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [2:0]                   status,
    output logic [uxv_pkg::CP_BITS-1:0]  code_point,
    output logic [uxv_pkg::POS_BITS-1:0] position
);
    import uxv_pkg::*;

    state_t  state_reg;
    state_t  state_next;
    result_t step_res;
    logic    step_valid;
    logic    accept;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_res_reg;

    // Request handshake: hold off only while a stalled result occupies the output.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    uxv_step u_step (
        .cur       (state_reg),
        .mode      (mode),
        .data_byte (data_byte),
        .nxt       (state_next),
        .res_valid (step_valid),
        .res       (step_res)
    );

    // Decoder state advances on every accepted request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (accept)
            state_reg <= state_next;
    end

    // Output register valid: load on accept, drain when the sink takes it.
    always_comb
    begin
        if (accept)
            out_valid_next = step_valid;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (accept && step_valid)
            out_res_reg <= step_res;
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_res_reg.status;
    assign code_point = out_res_reg.code_point;
    assign position   = out_res_reg.position;

endmodule

FILE: rtl/uxv_step.sv
// Combinational next-state and result logic for one input request of the validator.
// Depends on uxv_pkg for the state and result types and the status codes.
`timescale 1ns / 1ps

module uxv_step (
    input  uxv_pkg::state_t  cur,
    input  logic             mode,
    input  logic [7:0]       data_byte,
    output uxv_pkg::state_t  nxt,
    output logic             res_valid,
    output uxv_pkg::result_t res
);
    import uxv_pkg::*;

    logic [OFFSET_BITS-1:0] here;
    logic [CP_BITS-1:0]     pv_shift;
    logic [1:0]             br_dec;

    // Continuation byte merged into the open sequence.
    assign here     = cur.byte_count;
    assign pv_shift = {cur.partial_value[CP_BITS-7:0], data_byte[5:0]};
    assign br_dec   = cur.bytes_remaining - 2'd1;

    // One decode step; an error makes the state sticky.
    always_comb
    begin
        nxt       = cur;
        res_valid = 1'b0;
        res       = '0;
        if (cur.failed)
        begin
            res_valid = 1'b1;
            res       = '{cur.error_code, '0, off_to_pos(cur.error_position)};
        end
        else if (mode == MODE_END)
        begin
            res_valid = 1'b1;
            if (cur.bytes_remaining != 2'd0)
            begin
                nxt.failed         = 1'b1;
                nxt.error_code     = ST_MALFORMED;
                nxt.error_position = cur.sequence_start;
                res = '{ST_MALFORMED, '0, off_to_pos(cur.sequence_start)};
            end
            else
            begin
                nxt.ended = 1'b1;
                res       = '{ST_END_OK, '0, off_to_pos(cur.byte_count)};
            end
        end
        else if (cur.ended || cur.byte_count == OFF_MAX)
        begin
            res_valid          = 1'b1;
            nxt.failed         = 1'b1;
            nxt.error_code     = cur.ended ? ST_AFTER_END : ST_LIMIT;
            nxt.error_position = cur.byte_count;
            res = '{nxt.error_code, '0, off_to_pos(cur.byte_count)};
        end
        else
        begin
            nxt.byte_count = cur.byte_count + OFFSET_BITS'(1);
            if (cur.bytes_remaining == 2'd0)
            begin
                // Lead byte or single-byte character.
                if (!data_byte[7])
                begin
                    res_valid = 1'b1;
                    if (!xml_scalar_ok(CP_BITS'(data_byte)))
                    begin
                        nxt.failed         = 1'b1;
                        nxt.error_code     = ST_MALFORMED;
                        nxt.error_position = here;
                        res = '{ST_MALFORMED, '0, off_to_pos(here)};
                    end
                    else
                    begin
                        res = '{ST_SCALAR, CP_BITS'(data_byte), off_to_pos(here)};
                    end
                end
                else
                begin
                    nxt.sequence_start = here;
                    if ((data_byte & 8'hE0) == 8'hC0)
                    begin
                        nxt.partial_value   = CP_BITS'(data_byte[4:0]);
                        nxt.minimum_value   = MIN_TWO;
                        nxt.bytes_remaining = 2'd1;
                    end
                    else if ((data_byte & 8'hF0) == 8'hE0)
                    begin
                        nxt.partial_value   = CP_BITS'(data_byte[3:0]);
                        nxt.minimum_value   = MIN_THREE;
                        nxt.bytes_remaining = 2'd2;
                    end
                    else if ((data_byte & 8'hF8) == 8'hF0)
                    begin
                        nxt.partial_value   = CP_BITS'(data_byte[2:0]);
                        nxt.minimum_value   = MIN_FOUR;
                        nxt.bytes_remaining = 2'd3;
                    end
                    else
                    begin
                        res_valid          = 1'b1;
                        nxt.failed         = 1'b1;
                        nxt.error_code     = ST_MALFORMED;
                        nxt.error_position = here;
                        res = '{ST_MALFORMED, '0, off_to_pos(here)};
                    end
                end
            end
            else if (data_byte[7:6] != 2'b10)
            begin
                // Expected a continuation byte.
                res_valid          = 1'b1;
                nxt.failed         = 1'b1;
                nxt.error_code     = ST_MALFORMED;
                nxt.error_position = here;
                res = '{ST_MALFORMED, '0, off_to_pos(here)};
            end
            else
            begin
                nxt.partial_value   = pv_shift;
                nxt.bytes_remaining = br_dec;
                if (br_dec == 2'd0)
                begin
                    // Sequence complete: check overlong form and XML range.
                    res_valid = 1'b1;
                    if (pv_shift < CP_BITS'(cur.minimum_value) || !xml_scalar_ok(pv_shift))
                    begin
                        nxt.failed         = 1'b1;
                        nxt.error_code     = ST_MALFORMED;
                        nxt.error_position = cur.sequence_start;
                        res = '{ST_MALFORMED, '0, off_to_pos(cur.sequence_start)};
                    end
                    else
                    begin
                        res = '{ST_SCALAR, pv_shift, off_to_pos(cur.sequence_start)};
                    end
                end
            end
        end
    end

endmodule

FILE: rtl/uxv_checker.sv
// Port-level checker for utf8_xml_scalar_validator, attached by the bind at the end.
// Depends on uxv_pkg for status codes and field widths.
`timescale 1ns / 1ps

module uxv_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [2:0]                   status,
    input logic [uxv_pkg::CP_BITS-1:0]  code_point,
    input logic [uxv_pkg::POS_BITS-1:0] position
);
    import uxv_pkg::*;

    logic                err_seen_reg;
    logic                err_seen_next;
    logic [2:0]          err_status_reg;
    logic [POS_BITS-1:0] err_pos_reg;
    logic                out_take;
    logic                is_error;

    assign out_take = out_valid && !out_stall;
    assign is_error = status == ST_MALFORMED || status == ST_LIMIT || status == ST_AFTER_END;
    assign err_seen_next = err_seen_reg || (out_take && is_error);

    // Remember the first error result delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            err_seen_reg <= 1'b0;
        else
            err_seen_reg <= err_seen_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_take && is_error && !err_seen_reg)
        begin
            err_status_reg <= status;
            err_pos_reg    <= position;
        end
    end

    // Once an error has gone out, every later result repeats it.
    a_sticky_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && err_seen_reg |->
            status == err_status_reg && position == err_pos_reg && code_point == '0)
        else $error("error result not repeated after first error");

    // Only scalar results carry a code point.
    a_cp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_SCALAR |-> code_point == '0)
        else $error("nonzero code point on non-scalar result");

    // A delivered scalar is a legal XML character.
    a_scalar_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_SCALAR |-> xml_scalar_ok(code_point))
        else $error("scalar result outside XML character range");

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            out_valid && $stable(status) && $stable(code_point) && $stable(position))
        else $error("stalled result changed");

endmodule

bind utf8_xml_scalar_validator uxv_checker u_uxv_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .code_point (code_point),
    .position   (position)
);

FILE: sim/tb.sv
// Self-checking testbench for the UTF-8 / XML scalar validator.
// Depends on uxv_pkg and the utf8_xml_scalar_validator RTL; reads no files.
`timescale 1ns / 1ps

module tb;
    import uxv_pkg::*;

    localparam int RANDOM_TARGET  = 1250;
    localparam int NOISE_REQS     = 40;
    localparam int HOLD_AFTER     = 150;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int START_ROWS     = 26;

    // How the stream is broken once the clean part is done.
    typedef enum int {
        TAIL_BAD_ASCII,
        TAIL_BAD_LEAD,
        TAIL_BAD_CONT,
        TAIL_OVERLONG,
        TAIL_SURROGATE,
        TAIL_TOO_BIG,
        TAIL_NON_XML,
        TAIL_OPEN_AT_END,
        TAIL_CLEAN_END
    } tail_kind_t;

    // One request to send, with an optional expectation written by hand.
    typedef struct {
        logic       md;
        logic [7:0] b;
        bit         typed;
        bit         yields;
        result_t    want;
    } byte_req_t;

    typedef struct packed {
        logic       md;
        logic [7:0] b;
        logic       yields;
        result_t    want;
    } start_row_t;

    // Decoder state as the scoreboard tracks it.
    typedef struct packed {
        logic [CP_BITS-1:0]     acc;
        logic [MIN_BITS-1:0]    floor_cp;
        logic [1:0]             pending;
        logic [OFFSET_BITS-1:0] lead_pos;
        logic [OFFSET_BITS-1:0] count;
        logic                   done;
        logic                   dead;
        logic [2:0]             err_status;
        logic [OFFSET_BITS-1:0] err_pos;
    } dec_state_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                mode      = MODE_DATA;
    logic [7:0]          data_byte = 8'h00;
    logic                out_stall = 1'b0;
    logic                in_stall;
    logic                out_valid;
    logic [2:0]          status;
    logic [CP_BITS-1:0]  code_point;
    logic [POS_BITS-1:0] position;

    byte_req_t   req_q[$];
    result_t     expected_q[$];
    dec_state_t  dec = '0;
    int unsigned n_reqs = 0;
    int unsigned taken_reqs = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    int unsigned idle_phase = 0;

    // Valid boundary scalars from offset zero; expectations read straight off the encoding.
    start_row_t start_rows [START_ROWS] = '{
        '{MODE_DATA, 8'h09, 1'b1, '{ST_SCALAR, 21'h00009, 48'd0}},
        '{MODE_DATA, 8'h0A, 1'b1, '{ST_SCALAR, 21'h0000A, 48'd1}},
        '{MODE_DATA, 8'h0D, 1'b1, '{ST_SCALAR, 21'h0000D, 48'd2}},
        '{MODE_DATA, 8'h7F, 1'b1, '{ST_SCALAR, 21'h0007F, 48'd3}},
        '{MODE_DATA, 8'hC2, 1'b0, '{ST_SCALAR, 21'h0, 48'd0}},
        '{MODE_DATA, 8'h80, 1'b1, '{ST_SCALAR, 21'h00080, 48'd4}},
        '{MODE_DATA, 8'hE0, 1'b0, '{ST_SCALAR, 21'h0, 48'd0}},
        '{MODE_DATA, 8'hA0, 1'b0, '{ST_SCALAR, 21'h0, 48'd0}},
        '{MODE_DATA, 8'h80, 1'b1, '{ST_SCALAR, 21'h00800, 48'd6}},
        '{MODE_DATA, 8'hED, 1'b0, '{ST_SCALAR, 21'h0, 48'd0}},
        '{MODE_DATA, 8'h9F, 1'b0, '{ST_SCALAR, 21'h0, 48'd0}},
        '{MODE_DATA, 8'hBF, 1'b1, '{ST_SCALAR, 21'h0D7FF, 48'd9}},
        '{MODE_DATA, 8'hEE, 1'b0, '{ST_SCALAR, 21'h0, 48'd0}},
        '{MODE_DATA, 8'h80, 1'b0, '{ST_SCALAR, 21'h0, 48'd0}},
        '{MODE_DATA, 8'h80, 1'b1, '{ST_SCALAR, 21'h0E000, 48'd12}},
        '{MODE_DATA, 8'hEF, 1'b0, '{ST_SCALAR, 21'h0, 48'd0}},
        '{MODE_DATA, 8'hBF, 1'b0, '{ST_SCALAR, 21'h0, 48'd0}},
        '{MODE_DATA, 8'hBD, 1'b1, '{ST_SCALAR, 21'h0FFFD, 48'd15}},
        '{MODE_DATA, 8'hF0, 1'b0, '{ST_SCALAR, 21'h0, 48'd0}},
        '{MODE_DATA, 8'h90, 1'b0, '{ST_SCALAR, 21'h0, 48'd0}},
        '{MODE_DATA, 8'h80, 1'b0, '{ST_SCALAR, 21'h0, 48'd0}},
        '{MODE_DATA, 8'h80, 1'b1, '{ST_SCALAR, 21'h10000, 48'd18}},
        '{MODE_DATA, 8'hF4, 1'b0, '{ST_SCALAR, 21'h0, 48'd0}},
        '{MODE_DATA, 8'h8F, 1'b0, '{ST_SCALAR, 21'h0, 48'd0}},
        '{MODE_DATA, 8'hBF, 1'b0, '{ST_SCALAR, 21'h0, 48'd0}},
        '{MODE_DATA, 8'hBF, 1'b1, '{ST_SCALAR, 21'h10FFFF, 48'd22}}
    };

    utf8_xml_scalar_validator u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .code_point (code_point),
        .position   (position)
    );

    always #5 clk = ~clk;

    // Characters that XML allows.
    function automatic bit xml_allows(input logic [CP_BITS-1:0] v);
        return v == 21'h09 || v == 21'h0A || v == 21'h0D ||
               (v >= 21'h20 && v <= 21'hD7FF) ||
               (v >= 21'hE000 && v <= 21'hFFFD) ||
               (v >= 21'h10000 && v <= 21'h10FFFF);
    endfunction

    // Record the first error; from here on every request repeats it.
    function automatic bit latch_error(input logic [2:0] code,
                                       input logic [OFFSET_BITS-1:0] at_off,
                                       output result_t r);
        dec.dead       = 1'b1;
        dec.err_status = code;
        dec.err_pos    = at_off;
        r              = '0;
        r.status       = code;
        r.position     = at_off;
        return 1'b1;
    endfunction

    // Advance the decoder by one request; returns 1 when a result is due.
    function automatic bit decode_request(input logic md, input logic [7:0] b,
                                          output result_t r);
        logic [OFFSET_BITS-1:0] here;
        r = '0;
        if (dec.dead)
        begin
            r.status   = dec.err_status;
            r.position = dec.err_pos;
            return 1'b1;
        end
        if (md == MODE_END)
        begin
            if (dec.pending != 2'd0)
                return latch_error(ST_MALFORMED, dec.lead_pos, r);
            dec.done   = 1'b1;
            r.status   = ST_END_OK;
            r.position = dec.count;
            return 1'b1;
        end
        if (dec.done)
            return latch_error(ST_AFTER_END, dec.count, r);
        // Needs 2^48 - 1 bytes first, so it is out of reach in simulation.
        if (dec.count == OFF_MAX)
            return latch_error(ST_LIMIT, dec.count, r);

        here      = dec.count;
        dec.count = dec.count + 1'b1;

        // Single byte or the lead of a longer sequence.
        if (dec.pending == 2'd0)
        begin
            if (!b[7])
            begin
                if (!xml_allows(CP_BITS'(b)))
                    return latch_error(ST_MALFORMED, here, r);
                r.status     = ST_SCALAR;
                r.code_point = CP_BITS'(b);
                r.position   = here;
                return 1'b1;
            end
            dec.lead_pos = here;
            casez (b)
                8'b110?????:
                begin
                    dec.acc      = CP_BITS'(b[4:0]);
                    dec.floor_cp = MIN_TWO;
                    dec.pending  = 2'd1;
                end
                8'b1110????:
                begin
                    dec.acc      = CP_BITS'(b[3:0]);
                    dec.floor_cp = MIN_THREE;
                    dec.pending  = 2'd2;
                end
                8'b11110???:
                begin
                    dec.acc      = CP_BITS'(b[2:0]);
                    dec.floor_cp = MIN_FOUR;
                    dec.pending  = 2'd3;
                end
                default:
                    return latch_error(ST_MALFORMED, here, r);
            endcase
            return 1'b0;
        end

        // Continuation byte.
        if (b[7:6] != 2'b10)
            return latch_error(ST_MALFORMED, here, r);
        dec.acc     = {dec.acc[CP_BITS-7:0], b[5:0]};
        dec.pending = dec.pending - 1'b1;
        if (dec.pending != 2'd0)
            return 1'b0;
        if (dec.acc < CP_BITS'(dec.floor_cp) || !xml_allows(dec.acc))
            return latch_error(ST_MALFORMED, dec.lead_pos, r);
        r.status     = ST_SCALAR;
        r.code_point = dec.acc;
        r.position   = dec.lead_pos;
        return 1'b1;
    endfunction

    task automatic queue_req(input logic md, input logic [7:0] b);
        byte_req_t q;
        q.md     = md;
        q.b      = b;
        q.typed  = 1'b0;
        q.yields = 1'b0;
        q.want   = '0;
        req_q.push_back(q);
    endtask

    // Stimulus build, reset, request driver and end of run.
    initial
    begin : main
        byte_req_t          q;
        tail_kind_t         tail;
        logic [CP_BITS-1:0] cp;
        logic [7:0]         b;
        int unsigned        pick;
        int unsigned        len;
        int unsigned        idx;
        int unsigned        gap;

        // Directed boundary scalars.
        for (int i = 0; i < START_ROWS; i++)
        begin
            q.md     = start_rows[i].md;
            q.b      = start_rows[i].b;
            q.typed  = 1'b1;
            q.yields = start_rows[i].yields;
            q.want   = start_rows[i].want;
            req_q.push_back(q);
        end

        // Well-formed text with random scalars of every length.
        while (req_q.size() < RANDOM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                case ($urandom_range(0, 2))
                    0: cp = 21'h09;
                    1: cp = 21'h0A;
                    default: cp = 21'h0D;
                endcase
            end
            else if (pick < 35)
                cp = CP_BITS'($urandom_range(21'h20, 21'h7F));
            else if (pick < 55)
                cp = CP_BITS'($urandom_range(21'h80, 21'h7FF));
            else if (pick < 70)
                cp = CP_BITS'($urandom_range(21'h800, 21'hD7FF));
            else if (pick < 80)
                cp = CP_BITS'($urandom_range(21'hE000, 21'hFFFD));
            else
                cp = CP_BITS'($urandom_range(21'h10000, 21'h10FFFF));

            if (cp < 21'h80)
                queue_req(MODE_DATA, cp[7:0]);
            else if (cp < 21'h800)
            begin
                queue_req(MODE_DATA, {3'b110, cp[10:6]});
                queue_req(MODE_DATA, {2'b10, cp[5:0]});
            end
            else if (cp < 21'h10000)
            begin
                queue_req(MODE_DATA, {4'b1110, cp[15:12]});
                queue_req(MODE_DATA, {2'b10, cp[11:6]});
                queue_req(MODE_DATA, {2'b10, cp[5:0]});
            end
            else
            begin
                queue_req(MODE_DATA, {5'b11110, cp[20:18]});
                queue_req(MODE_DATA, {2'b10, cp[17:12]});
                queue_req(MODE_DATA, {2'b10, cp[11:6]});
                queue_req(MODE_DATA, {2'b10, cp[5:0]});
            end
        end

        // The first error is sticky, so one way of ending the stream is picked per run.
        tail = tail_kind_t'($urandom_range(0, int'(TAIL_CLEAN_END)));
        case (tail)
            TAIL_BAD_ASCII:
            begin
                do b = 8'($urandom_range(0, 31));
                while (b == 8'h09 || b == 8'h0A || b == 8'h0D);
                queue_req(MODE_DATA, b);
            end
            TAIL_BAD_LEAD:
            begin
                if ($urandom_range(0, 1) == 0)
                    queue_req(MODE_DATA, 8'($urandom_range(8'h80, 8'hBF)));
                else
                    queue_req(MODE_DATA, 8'($urandom_range(8'hF8, 8'hFF)));
            end
            TAIL_BAD_CONT, TAIL_OPEN_AT_END:
            begin
                len = $urandom_range(2, 4);
                queue_req(MODE_DATA, len == 2 ? 8'hC3 : (len == 3 ? 8'hE2 : 8'hF1));
                repeat ($urandom_range(0, len - 2))
                    queue_req(MODE_DATA, 8'h80 | 8'($urandom_range(0, 63)));
                if (tail == TAIL_OPEN_AT_END)
                    queue_req(MODE_END, 8'($urandom_range(0, 255)));
                else
                begin
                    do b = 8'($urandom_range(0, 255));
                    while (b[7:6] == 2'b10);
                    queue_req(MODE_DATA, b);
                end
            end
            TAIL_OVERLONG:
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        queue_req(MODE_DATA, 8'hC0 | 8'($urandom_range(0, 1)));
                        queue_req(MODE_DATA, 8'h80 | 8'($urandom_range(0, 63)));
                    end
                    1:
                    begin
                        queue_req(MODE_DATA, 8'hE0);
                        queue_req(MODE_DATA, 8'h80 | 8'($urandom_range(0, 31)));
                        queue_req(MODE_DATA, 8'h80 | 8'($urandom_range(0, 63)));
                    end
                    default:
                    begin
                        queue_req(MODE_DATA, 8'hF0);
                        queue_req(MODE_DATA, 8'h80 | 8'($urandom_range(0, 15)));
                        queue_req(MODE_DATA, 8'h80 | 8'($urandom_range(0, 63)));
                        queue_req(MODE_DATA, 8'h80 | 8'($urandom_range(0, 63)));
                    end
                endcase
            end
            TAIL_SURROGATE:
            begin
                queue_req(MODE_DATA, 8'hED);
                queue_req(MODE_DATA, 8'hA0 | 8'($urandom_range(0, 31)));
                queue_req(MODE_DATA, 8'h80 | 8'($urandom_range(0, 63)));
            end
            TAIL_TOO_BIG:
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    queue_req(MODE_DATA, 8'hF4);
                    queue_req(MODE_DATA, 8'($urandom_range(8'h90, 8'hBF)));
                end
                else
                begin
                    queue_req(MODE_DATA, 8'($urandom_range(8'hF5, 8'hF7)));
                    queue_req(MODE_DATA, 8'h80 | 8'($urandom_range(0, 63)));
                end
                queue_req(MODE_DATA, 8'h80 | 8'($urandom_range(0, 63)));
                queue_req(MODE_DATA, 8'h80 | 8'($urandom_range(0, 63)));
            end
            TAIL_NON_XML:
            begin
                queue_req(MODE_DATA, 8'hEF);
                queue_req(MODE_DATA, 8'hBF);
                queue_req(MODE_DATA, 8'($urandom_range(8'hBE, 8'hBF)));
            end
            default:
            begin
                // Clean end, answered twice; noise data then lands after the end.
                queue_req(MODE_END, 8'($urandom_range(0, 255)));
                queue_req(MODE_END, 8'($urandom_range(0, 255)));
            end
        endcase

        // Random noise afterwards: once an error is stored, every request must repeat it.
        repeat (NOISE_REQS)
            queue_req($urandom_range(0, 3) == 0 ? MODE_END : MODE_DATA,
                      8'($urandom_range(0, 255)));
        n_reqs = req_q.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Offer requests in order; a stalled request is held unchanged.
        idx = 0;
        while (idx < n_reqs)
        begin
            @(posedge clk);
            if (in_valid && !in_stall)
                idx++;
            idle_phase <= (3 * idx) / n_reqs;
            if (!in_valid || !in_stall)
            begin
                gap = (idle_phase == 0) ? 24 : ((idle_phase == 1) ? 57 : 0);
                if (idx < n_reqs && $urandom_range(0, 99) >= gap)
                begin
                    in_valid  <= 1'b1;
                    mode      <= req_q[idx].md;
                    data_byte <= req_q[idx].b;
                end
                else
                    in_valid <= 1'b0;
            end
        end

        // Drain, then give stray results a chance to show up.
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_q.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // Result sink: random stall per phase, plus one long hold-off to back the block up.
    initial
    begin : sink
        int unsigned seen;
        bit          held;
        int unsigned stall_pct;
        seen = 0;
        held = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                seen++;
            if (!held && seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall_pct = (idle_phase == 0) ? 57 : ((idle_phase == 1) ? 24 : 0);
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Scoreboard: check accepted results, then predict from accepted requests.
    always @(posedge clk)
    begin : score
        result_t want;
        result_t guess;
        bit      makes;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("status: expected no result, got %0d", status);
                    mismatches++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        mismatches++;
                    end
                    if (code_point !== want.code_point)
                    begin
                        $error("code_point: expected 0x%0h, got 0x%0h",
                               want.code_point, code_point);
                        mismatches++;
                    end
                    if (position !== want.position)
                    begin
                        $error("position: expected %0d, got %0d", want.position, position);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                makes = decode_request(mode, data_byte, guess);
                if (req_q[taken_reqs].typed)
                begin
                    makes = req_q[taken_reqs].yields;
                    guess = req_q[taken_reqs].want;
                end
                if (makes)
                    expected_q.push_back(guess);
                taken_reqs++;
            end
        end
    end

    // Watchdog on cycles with no request and no result moving.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

endmodule
